// ===== rtl/core/crc8cfs_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the command frame switch.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package crc8cfs_pkg;

  localparam int unsigned FrameBytes = 10;
  localparam logic [7:0] CmdMagic = 8'hA5;
  localparam logic [7:0] RspMagic = 8'h5A;
  localparam logic [7:0] ProtoVersion = 8'h01;
  localparam logic [7:0] OpSetPower = 8'h01;
  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [3:0] CountSat = 4'd11;
  localparam logic [3:0] LastPos = 4'(FrameBytes - 1);

  // Dense outcome code as seen on the status field.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_OPCODE = 2'd1,
    ST_BAD_VALUE  = 2'd2,
    ST_RELAY_FAIL = 2'd3
  } status_e;

  // Outcome code as carried in byte 3 of the reply.
  localparam logic [7:0] WireOk = 8'd0;
  localparam logic [7:0] WireBadOpcode = 8'd2;
  localparam logic [7:0] WireBadValue = 8'd3;
  localparam logic [7:0] WireRelayFail = 8'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
    logic       relay_fault;
  } in_word_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    status_e    status;
    logic       relay_on;
    logic       last_reply_byte;
  } out_word_t;

  // Everything the reply generator needs for one accepted command.
  typedef struct packed {
    logic [7:0]  opcode;
    status_e     status;
    logic [31:0] seq_bytes;
    logic        power;
  } job_t;

  // CRC-8, polynomial 0x07, MSB first, one byte per call.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] wire_code(input status_e st);
    logic [7:0] w;
    case (st)
      ST_OK:         w = WireOk;
      ST_BAD_OPCODE: w = WireBadOpcode;
      ST_BAD_VALUE:  w = WireBadValue;
      ST_RELAY_FAIL: w = WireRelayFail;
      default:       w = WireOk;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crc8cfs_front.sv =====
// Receive side: parses command bytes, checks the frame and updates the power state.
// Depends on crc8cfs_pkg; pushes one job per accepted frame.
`default_nettype none

module crc8cfs_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  take_i,
  input  crc8cfs_pkg::in_word_t word_i,
  output logic                 push_o,
  output crc8cfs_pkg::job_t    job_o
);

  logic [3:0]  count_q, count_d;
  logic [7:0]  crc_q, crc_d;
  logic        hdr_bad_q, hdr_bad_d;
  logic        power_q, power_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [31:0] seq_q, seq_d;
  logic [7:0]  value_q, value_d;
  logic        frame_ok;
  crc8cfs_pkg::status_e st;

  always_comb begin
    count_d   = count_q;
    crc_d     = crc_q;
    hdr_bad_d = hdr_bad_q;
    power_d   = power_q;
    opcode_d  = opcode_q;
    seq_d     = seq_q;
    value_d   = value_q;
    frame_ok  = 1'b0;
    st        = crc8cfs_pkg::ST_OK;
    push_o    = 1'b0;

    if (take_i) begin
      if (count_q == 4'd0 && word_i.rx_byte != crc8cfs_pkg::CmdMagic) hdr_bad_d = 1'b1;
      if (count_q == 4'd1 && word_i.rx_byte != crc8cfs_pkg::ProtoVersion) hdr_bad_d = 1'b1;
      if (count_q == 4'd2) opcode_d = word_i.rx_byte;
      // Sequence bytes shift in so that byte 4 lands in the top position.
      if (count_q >= 4'd4 && count_q <= 4'd7) seq_d = {seq_q[23:0], word_i.rx_byte};
      if (count_q == 4'd8) value_d = word_i.rx_byte;
      if (count_q <= 4'd8) crc_d = crc8cfs_pkg::crc8_feed(crc_q, word_i.rx_byte);
      if (count_q < crc8cfs_pkg::CountSat) count_d = count_q + 4'd1;

      frame_ok = word_i.end_of_frame && count_q == crc8cfs_pkg::LastPos && !hdr_bad_q &&
                 crc_q == word_i.rx_byte;

      if (word_i.end_of_frame) begin
        count_d   = 4'd0;
        crc_d     = 8'd0;
        hdr_bad_d = 1'b0;
      end

      if (frame_ok) begin
        push_o = 1'b1;
        if (opcode_q != crc8cfs_pkg::OpSetPower) begin
          st = crc8cfs_pkg::ST_BAD_OPCODE;
        end else if (value_q > 8'd1) begin
          st = crc8cfs_pkg::ST_BAD_VALUE;
        end else begin
          power_d = value_q[0];
          st = word_i.relay_fault ? crc8cfs_pkg::ST_RELAY_FAIL : crc8cfs_pkg::ST_OK;
        end
      end
    end

    job_o.opcode    = opcode_q;
    job_o.status    = st;
    job_o.seq_bytes = seq_q;
    job_o.power     = power_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= 4'd0;
      crc_q     <= 8'd0;
      hdr_bad_q <= 1'b0;
      power_q   <= 1'b0;
    end else begin
      count_q   <= count_d;
      crc_q     <= crc_d;
      hdr_bad_q <= hdr_bad_d;
      power_q   <= power_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opcode_q <= opcode_d;
    seq_q    <= seq_d;
    value_q  <= value_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/crc8cfs_queue.sv =====
// Two-entry job queue between the frame parser and the reply generator.
// Depends on crc8cfs_pkg for the job type.
`default_nettype none

module crc8cfs_queue (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  crc8cfs_pkg::job_t push_job_i,
  output logic              full_o,
  input  wire               pop_i,
  output logic              empty_o,
  output crc8cfs_pkg::job_t pop_job_o
);

  crc8cfs_pkg::job_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign full_o    = fill_q == 2'd2;
  assign empty_o   = fill_q == 2'd0;
  assign pop_job_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

endmodule

`default_nettype wire

// ===== rtl/core/crc8cfs_back.sv =====
// Reply generator: turns one job into ten reply words with a running CRC-8.
// Depends on crc8cfs_pkg; output goes through a single registered stage.
`default_nettype none

module crc8cfs_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   empty_i,
  input  crc8cfs_pkg::job_t     job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output crc8cfs_pkg::out_word_t out_word_o
);

  logic                   busy_q, busy_d;
  logic [3:0]             idx_q, idx_d;
  logic [7:0]             crc_q, crc_d;
  crc8cfs_pkg::job_t      job_q;
  logic                   ov_q, ov_d;
  crc8cfs_pkg::out_word_t ow_q, ow_d;
  logic                   advance, last;
  logic [7:0]             cur_byte;

  always_comb begin
    case (idx_q)
      4'd0:    cur_byte = crc8cfs_pkg::RspMagic;
      4'd1:    cur_byte = crc8cfs_pkg::ProtoVersion;
      4'd2:    cur_byte = job_q.opcode;
      4'd3:    cur_byte = crc8cfs_pkg::wire_code(job_q.status);
      4'd4:    cur_byte = job_q.seq_bytes[31:24];
      4'd5:    cur_byte = job_q.seq_bytes[23:16];
      4'd6:    cur_byte = job_q.seq_bytes[15:8];
      4'd7:    cur_byte = job_q.seq_bytes[7:0];
      4'd8:    cur_byte = {7'd0, job_q.power};
      4'd9:    cur_byte = crc_q;
      default: cur_byte = 8'd0;
    endcase
  end

  assign advance = busy_q && (!ov_q || out_ready_i);
  assign last    = idx_q == crc8cfs_pkg::LastPos;
  assign pop_o   = !empty_i && (!busy_q || (advance && last));

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    crc_d  = crc_q;
    ov_d   = ov_q && !out_ready_i;
    ow_d   = ow_q;
    if (advance) begin
      ov_d                 = 1'b1;
      ow_d.reply_byte      = cur_byte;
      ow_d.status          = job_q.status;
      ow_d.relay_on        = job_q.power;
      ow_d.last_reply_byte = last;
      crc_d                = crc8cfs_pkg::crc8_feed(crc_q, cur_byte);
      idx_d                = idx_q + 4'd1;
      if (last) busy_d = 1'b0;
    end
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = 4'd0;
      crc_d  = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 4'd0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    ow_q  <= ow_d;
    if (pop_o) job_q <= job_i;
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;

endmodule

`default_nettype wire

// ===== rtl/core/crc8_command_frame_switch.sv =====
// Top level of the CRC-8 command frame switch: front parser, job queue, reply generator.
// Depends on crc8cfs_pkg, crc8cfs_front, crc8cfs_queue and crc8cfs_back.
//
// Usage: command bytes arrive one word per cycle on the input channel (valid/ready),
// with end_of_frame on the last byte and relay_fault sampled with that last byte.
// A frame of exactly ten bytes with header A5 01 and a matching CRC-8 is executed;
// anything else is dropped with no reply. Each executed frame yields ten reply
// words on the output channel, the tenth flagged by last_reply_byte.
// Throughput: one input word per cycle while the two-entry job queue has room, and
// one reply word per cycle while the receiver is ready. The parser updates its CRC
// with a single unrolled eight-bit step per byte.
// The job of the last command byte passes through the job queue and the reply
// generator's job register before its first reply word enters the output register.
// When the receiver stalls, the reply word holds in the output register, the reply
// generator pauses, and the front keeps taking bytes until two finished jobs wait
// in the queue; only then does in_ready_o drop.
// Reset clears the frame parser, empties the queue, drops any reply in progress
// and clears the stored power state to off.
`default_nettype none

module crc8_command_frame_switch (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  crc8cfs_pkg::in_word_t  in_word_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output crc8cfs_pkg::out_word_t out_word_o
);

  logic              take;
  logic              push;
  crc8cfs_pkg::job_t push_job;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  crc8cfs_pkg::job_t pop_job;

  // A byte is taken only while the queue can hold the job an end of frame may create.
  assign in_ready_o = !q_full;
  assign take       = in_valid_i && in_ready_o;

  crc8cfs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .word_i (in_word_i),
    .push_o (push),
    .job_o  (push_job)
  );

  crc8cfs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_job_o  (pop_job)
  );

  crc8cfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
